// ----- rtl/argon2_block_compression_assert.svh -----
// Assertion macros shared by the Argon2 compression RTL.
// No dependencies; included inside module bodies.
`ifndef ARGON2_BLOCK_COMPRESSION_ASSERT_SVH
`define ARGON2_BLOCK_COMPRESSION_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define A2_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication outside reset.
`define A2_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/a2bc_pkg.sv -----
// Package for the Argon2 compression block: state codes and mixer schedule.
// No dependencies.
`timescale 1ns / 1ps
package a2bc_pkg;
   localparam int WORD_W = 64;

   // control sequencer states
   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_COPY  = 3'd1;
   localparam logic [2:0] ST_GLOAD = 3'd2;
   localparam logic [2:0] ST_GOP   = 3'd3;
   localparam logic [2:0] ST_GSTOR = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   // ALU step codes within one G call
   localparam logic [1:0] OP_MULADD = 2'd0;
   localparam logic [1:0] OP_XORROT = 2'd1;

   // sequencer status record: busy flag and state code
   typedef struct packed {
      logic       busy;
      logic [2:0] state;
   } seq_stat_type;

   // local lane index (0..15) of G operand for mixer m (0..7), slot (a,b,c,d)
   function automatic logic [3:0] g_lane(input logic [2:0] m, input logic [1:0] slot);
      logic [3:0] base;
      logic [3:0] r;
      base = {2'b00, m[1:0]};
      r = 4'd0;
      if (!m[2]) begin
         r = base + {slot, 2'b00};
      end else begin
         case (slot)
            2'd0: r = base;
            2'd1: r = {2'b01, m[1:0] + 2'd1};
            2'd2: r = {2'b10, m[1:0] + 2'd2};
            default: r = {2'b11, m[1:0] + 2'd3};
         endcase
      end
      return r;
   endfunction

   // global word index of lane for row pass (col=0) or column pass (col=1)
   function automatic logic [6:0] g_addr(input logic col, input logic [2:0] grp,
                                         input logic [3:0] lane);
      logic [6:0] r;
      if (!col) r = {grp, lane};
      else      r = {lane[3:1], grp, lane[0]};
      return r;
   endfunction
endpackage

// ----- rtl/a2bc_alu.sv -----
// Shared G step unit: one multiply-add or xor-rotate per cycle, registered.
// Depends on a2bc_pkg.
`timescale 1ns / 1ps
module a2bc_alu (
   input  logic        clock,
   input  logic [1:0]  op,
   input  logic [1:0]  rot_sel,
   input  logic [63:0] x,
   input  logic [63:0] y,
   output logic [63:0] res
);
   import a2bc_pkg::*;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] sum_ff, sum_in;
   logic        isadd_ff;
   logic [63:0] v;
   logic [63:0] rot;

   // stage 1: 32x32 product, x+y, or xor-rotate
   assign v = x ^ y;
   always_comb begin
      prod_in = 64'(x[31:0] * y[31:0]);
      case (rot_sel)
         2'd0: rot = {v[31:0], v[63:32]};
         2'd1: rot = {v[23:0], v[63:24]};
         2'd2: rot = {v[15:0], v[63:16]};
         default: rot = {v[62:0], v[63]};
      endcase
      sum_in = (op == OP_MULADD) ? x + y : rot;
   end
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      isadd_ff <= (op == OP_MULADD);
   end
   // stage 2: add doubled product
   assign res = isadd_ff ? sum_ff + {prod_ff[62:0], 1'b0} : sum_ff;
endmodule

// ----- rtl/argon2_block_compression.sv -----
// Argon2 compression G: load, permute with a shared G step unit, emit.
// Depends on a2bc_pkg, a2bc_alu and argon2_block_compression_assert.svh.
// Usage:
//  Input: pulse start with a word pair of prev and ref; accepted while busy
//  is low. Pairs 0..62 are stored while busy stays low.
//  The 64th pair starts the permutation; busy rises and stays high until
//  all 64 result beats are out.
//  Permutation: copy the block to the work store, then 16 rounds x 8 G
//  calls; each G loads 4 words, runs 8 ALU steps through the 2-stage ALU
//  and stores 4 words back.
//  Output: 64 beats, rsp_valid marks each, rsp_last_pair on the final one.
//  The receiver cannot stall; beats are not held.
//  Throughput is set by the single memory port and the serial G unit.
//  Reset: synchronous; clears the pair count, sequencer and valid flags
//  only; the stores are written before they are read.
`timescale 1ns / 1ps
module argon2_block_compression #(
   parameter int BLOCK_WORDS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_prev_even,
   input  logic [63:0] req_prev_odd,
   input  logic [63:0] req_ref_even,
   input  logic [63:0] req_ref_odd,
   output logic        rsp_valid,
   output logic [63:0] rsp_out_even,
   output logic [63:0] rsp_out_odd,
   output logic        rsp_last_pair
);
   import a2bc_pkg::*;
   `include "argon2_block_compression_assert.svh"

   localparam int AW = $clog2(BLOCK_WORDS);
   localparam int PW = AW - 1;

   // stores
   logic [63:0] xmem [BLOCK_WORDS];
   logic [63:0] wmem [BLOCK_WORDS];
   logic [63:0] lanes_ff [4];

   logic [2:0]    state_ff, state_in;
   logic [PW-1:0] pair_ff, pair_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          col_ff, col_in;
   logic [2:0]    grp_ff, grp_in;
   logic [2:0]    mix_ff, mix_in;
   logic [4:0]    step_ff, step_in;
   logic          accept;
   logic [AW-1:0] gaddr;
   logic [1:0]    slot;
   logic [63:0]   xrd_ff, wrd_ff;
   logic          cpv_ff;
   logic [AW-1:0] cpa_ff;
   logic          ov_ff, ol_ff;
   logic [63:0]   oe_ff, xo_ff, wo_ff;
   logic [63:0]   alu_res;
   logic [1:0]    op;
   logic [2:0]    k;
   logic [1:0]    dst, src;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_LOAD);

   // G slot for load/store sweeps
   assign slot  = step_ff[1:0];
   assign gaddr = AW'(g_addr(col_ff, grp_ff, g_lane(mix_ff, slot)));

   // step k of 8: op A: a+=b,c+=d ; xor-rot d^=a,b^=c alternating
   assign k = step_ff[4:2];
   always_comb begin
      op = k[0] ? OP_XORROT : OP_MULADD;
      case (k[1:0])
         2'd0: begin dst = 2'd0; src = 2'd1; end
         2'd1: begin dst = 2'd3; src = 2'd0; end
         2'd2: begin dst = 2'd2; src = 2'd3; end
         default: begin dst = 2'd1; src = 2'd2; end
      endcase
   end

   a2bc_alu u_alu (
      .clock(clock), .op(op), .rot_sel({k[2], k[1]}),
      .x(lanes_ff[dst]), .y(lanes_ff[src]), .res(alu_res)
   );

   // sequencer
   always_comb begin
      state_in = state_ff; pair_in = pair_ff; cnt_in = cnt_ff;
      col_in = col_ff; grp_in = grp_ff; mix_in = mix_ff; step_in = step_ff;
      case (state_ff)
         ST_LOAD: if (accept) begin
            pair_in = pair_ff + 1'b1;
            if (&pair_ff) begin state_in = ST_COPY; cnt_in = '0; end
         end
         ST_COPY: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(BLOCK_WORDS - 1)) begin
               state_in = ST_GLOAD; step_in = '0;
               col_in = 1'b0; grp_in = '0; mix_in = '0;
            end
         end
         ST_GLOAD: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd4) begin state_in = ST_GOP; step_in = '0; end
         end
         ST_GOP: begin
            // cnt counts the sub-cycles of each step
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[1:0] == 2'd2) begin
               cnt_in = '0; step_in = step_ff + 5'd4;
               if (step_ff[4:2] == 3'd7) begin state_in = ST_GSTOR; step_in = '0; end
            end
         end
         ST_GSTOR: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd3) begin
               state_in = ST_GLOAD; step_in = '0; cnt_in = '0;
               mix_in = mix_ff + 1'b1;
               if (&mix_ff) begin
                  grp_in = grp_ff + 1'b1;
                  if (&grp_ff) begin
                     col_in = 1'b1;
                     if (col_ff) begin state_in = ST_OUT; cnt_in = '0; end
                  end
               end
            end
         end
         ST_OUT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(BLOCK_WORDS + 1)) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; pair_ff <= '0; cnt_ff <= '0; col_ff <= 1'b0;
         grp_ff <= '0; mix_ff <= '0; step_ff <= '0;
         cpv_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pair_ff <= pair_in; cnt_ff <= cnt_in;
         col_ff <= col_in; grp_ff <= grp_in; mix_ff <= mix_in; step_ff <= step_in;
         cpv_ff <= (state_ff == ST_COPY);
         ov_ff  <= (state_ff == ST_OUT) && cnt_ff >= (AW+1)'(2)
                   && cnt_ff[0] == 1'b0;
      end
   end

   // R store: pair write on load; one read port for copy and output
   always_ff @(posedge clock) begin
      if (accept) begin
         xmem[{pair_ff, 1'b0}] <= req_prev_even ^ req_ref_even;
         xmem[{pair_ff, 1'b1}] <= req_prev_odd ^ req_ref_odd;
      end
      xrd_ff <= xmem[cnt_ff[AW-1:0]];
      cpa_ff <= cnt_ff[AW-1:0];
   end

   // work store: one read port, one write port
   always_ff @(posedge clock) begin
      if (cpv_ff) wmem[cpa_ff] <= xrd_ff;
      else if (state_ff == ST_GSTOR) wmem[gaddr] <= lanes_ff[slot];
      wrd_ff <= wmem[(state_ff == ST_OUT) ? cnt_ff[AW-1:0] : gaddr];
   end

   // lane registers: loaded from the work store, updated by ALU writeback
   always_ff @(posedge clock) begin
      if (state_ff == ST_GLOAD && step_ff != 5'd0)
         lanes_ff[step_ff[1:0] - 2'd1] <= wrd_ff;
      if (state_ff == ST_GOP && cnt_ff[1:0] == 2'd2)
         lanes_ff[dst] <= alu_res;
   end

   // output pairing: even word then odd word, one beat per pair
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && cnt_ff != '0) begin
         if (cnt_ff[0] == 1'b1) oe_ff <= xrd_ff ^ wrd_ff;
         xo_ff <= xrd_ff; wo_ff <= wrd_ff;
      end
      ol_ff <= (cnt_ff == (AW+1)'(BLOCK_WORDS));
   end
   assign rsp_valid     = ov_ff && cnt_ff[0] == 1'b1;
   assign rsp_out_even  = oe_ff;
   assign rsp_out_odd   = xo_ff ^ wo_ff;
   assign rsp_last_pair = rsp_valid && ol_ff;

   `A2_ASSERT_IMP(a_no_accept_busy, clock, reset, busy, !accept)
   `A2_ASSERT_IMP(a_rsp_only_out, clock, reset, rsp_valid, state_ff == ST_OUT)
   `A2_ASSERT_NEXT(a_last_ends, clock, reset, rsp_last_pair, !rsp_valid)
   `A2_ASSERT_IMP(a_last_pair_zero, clock, reset, rsp_valid, pair_ff == '0)
endmodule
